FILE: src/key_event_classifier_defines.svh
// ----------------------------------------------------------------------------
// Key event classifier assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef KEY_EVENT_CLASSIFIER_DEFINES_SVH
`define KEY_EVENT_CLASSIFIER_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define KEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define KEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/kec_pkg.sv
// ----------------------------------------------------------------------------
// Key event classifier package
// Sizes, codes, per-key record layout and controller/datapath interface types.
// ----------------------------------------------------------------------------
package kec_pkg;

  localparam int NUM_KEYS  = 512;
  localparam int ADDR_W    = $clog2(NUM_KEYS);
  localparam int KEY_W     = 9;
  // Wide enough to compare a key index against any supported key count.
  localparam int KEY_CMP_W = 11;
  localparam int TIME_W    = 48;
  localparam int CFG_W     = 16;
  localparam int KIND_W    = 3;
  localparam int MAX_EV    = 3;
  localparam int EV_IDX_W  = 2;
  localparam int DIV_CNT_W = $clog2(TIME_W);

  typedef logic [TIME_W-1:0] tstamp_t;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_PRESS   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_REPEAT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_DOUBLE_WINDOW   = 2'd0,
    REG_HOLD_DELAY      = 2'd1,
    REG_REPEAT_DELAY    = 2'd2,
    REG_REPEAT_INTERVAL = 2'd3
  } cfg_reg_e;

  typedef enum logic [KIND_W-1:0] {
    EV_PRESSED  = 3'd0,
    EV_RELEASED = 3'd1,
    EV_SINGLE   = 3'd2,
    EV_DOUBLE   = 3'd3,
    EV_HOLD     = 3'd4,
    EV_REPEAT   = 3'd5
  } ev_kind_e;

  localparam logic [CFG_W-1:0] DOUBLE_WINDOW_RST   = 16'd250;
  localparam logic [CFG_W-1:0] HOLD_DELAY_RST      = 16'd500;
  localparam logic [CFG_W-1:0] REPEAT_DELAY_RST    = 16'd400;
  localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd50;

  typedef struct packed {
    logic arm;
    logic hold;
    logic pend;
    logic down;
  } key_flags_t;

  typedef struct packed {
    key_flags_t flags;
    tstamp_t    pressed;
    tstamp_t    last_press;
    tstamp_t    next_repeat;
  } key_entry_t;

  localparam int ENTRY_W = $bits(key_entry_t);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL_A,
    S_EVAL_B,
    S_EVAL_C,
    S_DIV,
    S_NEXT_RPT,
    S_WRITE,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic latch;
    logic load;
    logic eval_a;
    logic eval_b;
    logic eval_c;
    logic next_rpt;
    logic write_back;
    logic clr_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_ok;
    op_e  op;
    logic skip;
    logic rep_due;
    logic div_done;
    logic has_events;
    logic emit_last;
    logic clr_done;
  } status_t;

endpackage

FILE: src/kec_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module kec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

FILE: src/kec_div.sv
// ----------------------------------------------------------------------------
// Repeat catch-up remainder unit
// Restoring division, one dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module kec_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  kec_pkg::tstamp_t            dividend_i,
  input  logic [kec_pkg::CFG_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [kec_pkg::CFG_W-1:0]   rem_o
);

  logic                          run_q, done_q;
  logic [kec_pkg::DIV_CNT_W-1:0] cnt_q;
  kec_pkg::tstamp_t              quo_q;
  logic [kec_pkg::CFG_W-1:0]     rem_q, dsr_q;
  logic [kec_pkg::CFG_W:0]       trial;
  logic                          fits;

  assign trial = {rem_q, quo_q[kec_pkg::TIME_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == kec_pkg::DIV_CNT_W'(kec_pkg::TIME_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      quo_q <= quo_q << 1;
      if (fits) begin
        rem_q <= kec_pkg::CFG_W'(trial - {1'b0, dsr_q});
      end else begin
        rem_q <= trial[kec_pkg::CFG_W-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: src/kec_ctrl.sv
// ----------------------------------------------------------------------------
// Key event classifier controller
// Sequences clearing, read, evaluation, catch-up, write-back and emission.
// ----------------------------------------------------------------------------
module kec_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  kec_pkg::status_t  status_i,
  output kec_pkg::cmd_t     cmd_o,
  output logic              busy
);

  kec_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kec_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      kec_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_done) begin
          state_d = kec_pkg::S_IDLE;
        end
      end
      kec_pkg::S_IDLE: begin
        // Items that address no key or carry the ignored code are taken and dropped.
        if (start && status_i.in_ok) begin
          cmd_o.latch = 1'b1;
          state_d     = kec_pkg::S_READ;
        end
      end
      kec_pkg::S_READ: begin
        cmd_o.load = 1'b1;
        state_d    = kec_pkg::S_EVAL_A;
      end
      kec_pkg::S_EVAL_A: begin
        cmd_o.eval_a = 1'b1;
        if (status_i.skip) begin
          state_d = kec_pkg::S_IDLE;
        end else if (status_i.op == kec_pkg::OP_TICK) begin
          state_d = kec_pkg::S_EVAL_B;
        end else begin
          state_d = kec_pkg::S_WRITE;
        end
      end
      kec_pkg::S_EVAL_B: begin
        cmd_o.eval_b = 1'b1;
        state_d      = kec_pkg::S_EVAL_C;
      end
      kec_pkg::S_EVAL_C: begin
        cmd_o.eval_c = 1'b1;
        state_d      = status_i.rep_due ? kec_pkg::S_DIV : kec_pkg::S_WRITE;
      end
      kec_pkg::S_DIV: begin
        if (status_i.div_done) begin
          state_d = kec_pkg::S_NEXT_RPT;
        end
      end
      kec_pkg::S_NEXT_RPT: begin
        cmd_o.next_rpt = 1'b1;
        state_d        = kec_pkg::S_WRITE;
      end
      kec_pkg::S_WRITE: begin
        cmd_o.write_back = 1'b1;
        state_d = status_i.has_events ? kec_pkg::S_EMIT : kec_pkg::S_IDLE;
      end
      kec_pkg::S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (status_i.emit_last) begin
          state_d = kec_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = kec_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != kec_pkg::S_IDLE);

endmodule

FILE: src/kec_dp.sv
// ----------------------------------------------------------------------------
// Key event classifier datapath
// Settings, key state memory, time compares, event list and remainder unit.
// ----------------------------------------------------------------------------
module kec_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  kec_pkg::cmd_t                  cmd_i,
  output kec_pkg::status_t               status_o,
  input  logic [1:0]                     operation_i,
  input  logic [kec_pkg::KEY_W-1:0]      key_index_i,
  input  kec_pkg::tstamp_t               now_ms_i,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_index_i,
  input  logic [kec_pkg::CFG_W-1:0]      cfg_data_i,
  output logic [kec_pkg::KEY_W-1:0]      event_key_o,
  output logic [kec_pkg::KIND_W-1:0]     event_kind_o,
  output logic                           last_event_o
);

  logic [kec_pkg::CFG_W-1:0] dw_q, hd_q, rd_q, ri_q, iv;

  kec_pkg::op_e                     op_q;
  logic [kec_pkg::KEY_W-1:0]        key_q;
  kec_pkg::tstamp_t                 now_q;
  kec_pkg::key_entry_t              ent_q, ram_rdata, ram_wdata;
  kec_pkg::ev_kind_e                ev_q [kec_pkg::MAX_EV];
  logic [kec_pkg::EV_IDX_W-1:0]     ev_cnt_q, emit_idx_q;
  logic [kec_pkg::ADDR_W-1:0]       clr_cnt_q, ram_addr;
  logic                             ram_we;

  kec_pkg::tstamp_t                 gap_last, gap_press, rpt_late;
  logic                             rep_due, div_start, div_done;
  logic [kec_pkg::CFG_W-1:0]        div_rem;

  // Settings registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dw_q <= kec_pkg::DOUBLE_WINDOW_RST;
      hd_q <= kec_pkg::HOLD_DELAY_RST;
      rd_q <= kec_pkg::REPEAT_DELAY_RST;
      ri_q <= kec_pkg::REPEAT_INTERVAL_RST;
    end else if (cfg_we_i) begin
      case (kec_pkg::cfg_reg_e'(cfg_index_i))
        kec_pkg::REG_DOUBLE_WINDOW:   dw_q <= cfg_data_i;
        kec_pkg::REG_HOLD_DELAY:      hd_q <= cfg_data_i;
        kec_pkg::REG_REPEAT_DELAY:    rd_q <= cfg_data_i;
        kec_pkg::REG_REPEAT_INTERVAL: ri_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign iv = (ri_q == '0) ? kec_pkg::CFG_W'(1) : ri_q;

  assign gap_last  = now_q - ent_q.last_press;
  assign gap_press = now_q - ent_q.pressed;
  assign rpt_late  = now_q - ent_q.next_repeat;
  assign rep_due   = ent_q.flags.down && ent_q.flags.arm && (now_q >= ent_q.next_repeat);
  assign div_start = cmd_i.eval_c && rep_due;

  // Control counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      ev_cnt_q   <= '0;
      emit_idx_q <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.latch) begin
        ev_cnt_q   <= '0;
        emit_idx_q <= '0;
      end
      if (cmd_i.emit) begin
        emit_idx_q <= emit_idx_q + 1'b1;
      end
      if (cmd_i.eval_a) begin
        case (op_q)
          kec_pkg::OP_TICK: begin
            if (ent_q.flags.pend && gap_last >= kec_pkg::TIME_W'(dw_q)) begin
              ev_cnt_q <= kec_pkg::EV_IDX_W'(1);
            end
          end
          kec_pkg::OP_PRESS: begin
            if (!ent_q.flags.down) begin
              ev_cnt_q <= ent_q.flags.pend ? kec_pkg::EV_IDX_W'(2) : kec_pkg::EV_IDX_W'(1);
            end
          end
          kec_pkg::OP_RELEASE: begin
            if (ent_q.flags.down) begin
              ev_cnt_q <= kec_pkg::EV_IDX_W'(1);
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.eval_b && ent_q.flags.down && !ent_q.flags.hold &&
          gap_press >= kec_pkg::TIME_W'(hd_q)) begin
        ev_cnt_q <= ev_cnt_q + 1'b1;
      end
      if (div_start) begin
        ev_cnt_q <= ev_cnt_q + 1'b1;
      end
    end
  end

  // Item payload, working key record and event list.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= kec_pkg::op_e'(operation_i);
      key_q <= key_index_i;
      now_q <= now_ms_i;
    end
    if (cmd_i.load) begin
      ent_q <= ram_rdata;
    end
    if (cmd_i.eval_a) begin
      case (op_q)
        kec_pkg::OP_TICK: begin
          if (ent_q.flags.pend && gap_last >= kec_pkg::TIME_W'(dw_q)) begin
            ent_q.flags.pend <= 1'b0;
            ev_q[0]          <= kec_pkg::EV_SINGLE;
          end
        end
        kec_pkg::OP_PRESS: begin
          if (!ent_q.flags.down) begin
            ent_q.flags.down  <= 1'b1;
            ent_q.flags.arm   <= 1'b1;
            ent_q.flags.hold  <= 1'b0;
            ent_q.pressed     <= now_q;
            ent_q.next_repeat <= now_q + kec_pkg::TIME_W'(rd_q);
            ent_q.last_press  <= now_q;
            ev_q[0]           <= kec_pkg::EV_PRESSED;
            if (ent_q.flags.pend) begin
              // A second press inside the window closes the pair; a late one
              // reports the earlier press as single and stays pending itself.
              if (gap_last <= kec_pkg::TIME_W'(dw_q)) begin
                ent_q.flags.pend <= 1'b0;
                ev_q[1]          <= kec_pkg::EV_DOUBLE;
              end else begin
                ev_q[1] <= kec_pkg::EV_SINGLE;
              end
            end else begin
              ent_q.flags.pend <= 1'b1;
            end
          end
        end
        kec_pkg::OP_RELEASE: begin
          if (ent_q.flags.down) begin
            ent_q.flags.down <= 1'b0;
            ent_q.flags.arm  <= 1'b0;
            ev_q[0]          <= kec_pkg::EV_RELEASED;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.eval_b && ent_q.flags.down && !ent_q.flags.hold &&
        gap_press >= kec_pkg::TIME_W'(hd_q)) begin
      ent_q.flags.hold <= 1'b1;
      ev_q[ev_cnt_q]   <= kec_pkg::EV_HOLD;
    end
    if (div_start) begin
      ev_q[ev_cnt_q] <= kec_pkg::EV_REPEAT;
    end
    // Advance past now by whole intervals: now - (late mod interval) + interval.
    if (cmd_i.next_rpt) begin
      ent_q.next_repeat <= now_q - kec_pkg::TIME_W'(div_rem) + kec_pkg::TIME_W'(iv);
    end
  end

  kec_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rpt_late),
    .divisor_i  (iv),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_comb begin
    if (cmd_i.clr_step) begin
      ram_addr = clr_cnt_q;
    end else if (cmd_i.write_back) begin
      ram_addr = kec_pkg::ADDR_W'(key_q);
    end else begin
      ram_addr = kec_pkg::ADDR_W'(key_index_i);
    end
  end

  assign ram_we    = cmd_i.clr_step || cmd_i.write_back;
  assign ram_wdata = cmd_i.clr_step ? '0 : ent_q;

  kec_ram #(
    .WIDTH (kec_pkg::ENTRY_W),
    .DEPTH (kec_pkg::NUM_KEYS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (ram_we),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign status_o.in_ok = (kec_pkg::KEY_CMP_W'(key_index_i) <
                           kec_pkg::KEY_CMP_W'(kec_pkg::NUM_KEYS)) &&
                          (kec_pkg::op_e'(operation_i) != kec_pkg::OP_REPEAT);
  assign status_o.op         = op_q;
  assign status_o.skip       = ((op_q == kec_pkg::OP_PRESS) && ent_q.flags.down) ||
                               ((op_q == kec_pkg::OP_RELEASE) && !ent_q.flags.down);
  assign status_o.rep_due    = rep_due;
  assign status_o.div_done   = div_done;
  assign status_o.has_events = (ev_cnt_q != '0);
  assign status_o.emit_last  = (emit_idx_q == ev_cnt_q - 1'b1);
  assign status_o.clr_done   = (clr_cnt_q == kec_pkg::ADDR_W'(kec_pkg::NUM_KEYS - 1));

  assign event_key_o  = key_q;
  assign event_kind_o = ev_q[emit_idx_q];
  assign last_event_o = status_o.emit_last;

endmodule

FILE: src/key_event_classifier.sv
// ----------------------------------------------------------------------------
// Key event classifier
// Per-key press, release, single, double, hold and repeat event detection.
// ----------------------------------------------------------------------------
// A press or release passes read, first evaluation and write-back before its words;
// a tick also passes the hold and repeat checks and, when a repeat is due, the
// remainder unit and next-repeat update. Items are handled one at a time: the
// next start is taken only once busy has fallen; an ignored code never raises busy.
// Results cannot be stalled: each word shows for one cycle with event_valid_o.
// Reset loads the default settings and clears every key record (busy high).
//
// The controller walks one item through read, evaluation, optional catch-up,
// write-back and emission. The datapath holds the single-port key memory, all
// time compares and the serial remainder unit that rounds the next repeat
// time up by whole intervals. Items naming a key beyond the key count, or
// carrying the ignored repeat code, are taken without any result.
module key_event_classifier (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       operation_i,
  input  logic [kec_pkg::KEY_W-1:0]        key_index_i,
  input  logic [kec_pkg::TIME_W-1:0]       now_ms_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [1:0]                       cfg_index_i,
  input  logic [kec_pkg::CFG_W-1:0]        cfg_data_i,
  output logic                             event_valid_o,
  output logic [kec_pkg::KEY_W-1:0]        event_key_o,
  output logic [kec_pkg::KIND_W-1:0]       event_kind_o,
  output logic                             last_event_o
);

  kec_pkg::cmd_t    cmd;
  kec_pkg::status_t status;

  // Settings are taken only while no item is in flight or being started.
  assign cfg_ready_o = !busy && !start;

  kec_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  kec_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .operation_i  (operation_i),
    .key_index_i  (key_index_i),
    .now_ms_i     (now_ms_i),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .event_key_o  (event_key_o),
    .event_kind_o (event_kind_o),
    .last_event_o (last_event_o)
  );

  // A result word is on the ports exactly in the emission cycles.
  assign event_valid_o = cmd.emit;

endmodule

FILE: src/kec_checker.sv
// ----------------------------------------------------------------------------
// Key event classifier port checker
// Checks result sequencing against the command handshake.
// ----------------------------------------------------------------------------
`include "key_event_classifier_defines.svh"

module kec_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        event_valid_o,
  input logic [kec_pkg::KEY_W-1:0]   event_key_o,
  input logic                        last_event_o
);

  `KEC_ASSERT(a_event_while_busy, event_valid_o |-> busy, "result word while idle")
  `KEC_ASSERT_NEXT(a_no_event_after_start, start && !busy, !event_valid_o, "result right after start")
  `KEC_ASSERT_NEXT(a_last_ends_burst, event_valid_o && last_event_o, !event_valid_o, "result after last word")
  `KEC_ASSERT_NEXT(a_burst_contiguous, event_valid_o && !last_event_o, event_valid_o && $stable(event_key_o), "result burst broken")

endmodule

bind key_event_classifier kec_checker u_kec_checker (.*);
